[sv/nibble_cpu_execute_unit_macros.svh]
// ----------------------------------------------------------------------------
// nibble cpu execute unit assertion macros
// clocked concurrent assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef NIBBLE_CPU_EXECUTE_UNIT_MACROS_SVH
`define NIBBLE_CPU_EXECUTE_UNIT_MACROS_SVH

// property sampled on the rising edge, masked while reset is high
`define NCX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// antecedent in one cycle, consequent in the next
`define NCX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  `NCX_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

[sv/ncx_pkg.sv]
// ----------------------------------------------------------------------------
// ncx_pkg
// shared types and constants of the nibble cpu execute unit
// ----------------------------------------------------------------------------
package ncx_pkg;

  localparam int NUM_REGS   = 16;
  localparam int REG_W      = 8;
  localparam int NIB_W      = 4;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 8;

  localparam logic [NIB_W-1:0] ACC_REG   = 4'h0;
  localparam logic [NIB_W-1:0] COUNT_REG = 4'hd;
  localparam logic [NIB_W-1:0] FLAG_REG  = 4'he;
  localparam logic [NIB_W-1:0] ZERO_REG  = 4'hf;

  localparam logic [REG_W-1:0] FLAG_RESET = 8'h03;
  localparam logic [REG_W-1:0] FLAG_KEEP  = 8'hc0;

  typedef enum logic [NIB_W-1:0] {
    OP_STOP   = 4'h0,
    OP_WRITE  = 4'h1,
    OP_COPY   = 4'h2,
    OP_SWAP   = 4'h3,
    OP_ALU    = 4'h4,
    OP_CMP    = 4'h5,
    OP_JUMP   = 4'h8,
    OP_BRANCH = 4'h9,
    OP_RET    = 4'ha,
    OP_COUNT  = 4'hb
  } op_t;

  typedef enum logic [NIB_W-1:0] {
    ALU_ADD  = 4'h0,
    ALU_SUB  = 4'h1,
    ALU_INC  = 4'h2,
    ALU_DEC  = 4'h3,
    ALU_NOT  = 4'h4,
    ALU_OR   = 4'h5,
    ALU_AND  = 4'h6,
    ALU_XOR  = 4'h7,
    ALU_SHL  = 4'h8,
    ALU_SHR  = 4'h9,
    ALU_ROL  = 4'ha,
    ALU_ROR  = 4'hb,
    ALU_NEG  = 4'hc,
    ALU_ISZ  = 4'hd,
    ALU_LOG  = 4'he,
    ALU_PASS = 4'hf
  } alu_mode_t;

  typedef enum logic [KIND_W-1:0] {
    RDR_NONE   = 2'd0,
    RDR_JUMP   = 2'd1,
    RDR_BRANCH = 2'd2,
    RDR_RETURN = 2'd3
  } rdr_kind_t;

  typedef struct packed {
    logic [NIB_W-1:0] op;
    logic [NIB_W-1:0] arg_first;
    logic [NIB_W-1:0] arg_second;
    logic [NIB_W-1:0] arg_third;
  } instr_t;

  // one register file write port
  typedef struct packed {
    logic             en;
    logic [NIB_W-1:0] addr;
    logic [REG_W-1:0] data;
  } wr_t;

  // result fields produced directly by the execute logic
  typedef struct packed {
    logic             halted;
    rdr_kind_t        kind;
    logic [REG_W-1:0] target;
  } ctl_t;

endpackage

[sv/ncx_alu.sv]
// ----------------------------------------------------------------------------
// ncx_alu
// sixteen-mode alu on r0 and r1 with flag generation
// ----------------------------------------------------------------------------
module ncx_alu
  import ncx_pkg::*;
(
  input  logic [NIB_W-1:0] mode,
  input  logic [REG_W-1:0] a,
  input  logic [REG_W-1:0] b,
  input  logic [REG_W-1:0] flags_old,
  output logic [REG_W-1:0] res,
  output logic [REG_W-1:0] flags_new
);

  logic [REG_W:0]   sum;
  logic             loss;
  logic [REG_W-1:0] msb_idx;

  assign sum = {1'b0, a} + {1'b0, b};

  // index of the highest set bit, all ones for zero
  always_comb begin
    msb_idx = '1;
    for (int i = 0; i < REG_W; i++) begin
      if (a[i]) msb_idx = REG_W'(i);
    end
  end

  always_comb begin
    loss = 1'b0;
    case (alu_mode_t'(mode))
      ALU_ADD: begin
        res  = sum[REG_W-1:0];
        loss = sum[REG_W];
      end
      ALU_SUB: begin
        // loss keeps the carry of the add
        res  = a - b;
        loss = sum[REG_W];
      end
      ALU_INC: res = a + 8'h01;
      ALU_DEC: res = a - 8'h01;
      ALU_NOT: res = ~a;
      ALU_OR:  res = a | b;
      ALU_AND: res = a & b;
      ALU_XOR: res = a ^ b;
      ALU_SHL: begin
        res  = {a[REG_W-2:0], 1'b0};
        loss = a[REG_W-1];
      end
      ALU_SHR: begin
        res  = {1'b0, a[REG_W-1:1]};
        loss = a[0];
      end
      ALU_ROL: res = {a[REG_W-2:0], a[REG_W-1]};
      ALU_ROR: res = {a[0], a[REG_W-1:1]};
      ALU_NEG: res = 8'h00 - a;
      ALU_ISZ: res = {{(REG_W-1){1'b0}}, (a == '0)};
      ALU_LOG: begin
        res  = msb_idx;
        loss = (a == '0);
      end
      default: res = a;
    endcase
  end

  // true, zero, negative, positive, odd, loss; top two bits kept
  assign flags_new = (flags_old & FLAG_KEEP)
                   | {2'b00, loss, res[0],
                      (res != '0) && !res[REG_W-1],
                      res[REG_W-1], (res == '0), 1'b1};

endmodule

[sv/ncx_regfile.sv]
// ----------------------------------------------------------------------------
// ncx_regfile
// 16 x 8 register file with two write ports; r15 always reads zero
// ----------------------------------------------------------------------------
module ncx_regfile
  import ncx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  wr_t              wa,
  input  wr_t              wb,
  input  logic [NIB_W-1:0] rd_x_addr,
  input  logic [NIB_W-1:0] rd_y_addr,
  output logic [REG_W-1:0] rd_x,
  output logic [REG_W-1:0] rd_y,
  output logic [REG_W-1:0] r0,
  output logic [REG_W-1:0] r1,
  output logic [REG_W-1:0] r13,
  output logic [REG_W-1:0] r14,
  output logic [REG_W-1:0] r0_next,
  output logic [REG_W-1:0] r14_next
);

  logic [REG_W-1:0] rf      [NUM_REGS];
  logic [REG_W-1:0] rf_next [NUM_REGS];

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_next[i] = rf[i];
      if (wa.en && wa.addr == NIB_W'(i)) rf_next[i] = wa.data;
      if (wb.en && wb.addr == NIB_W'(i)) rf_next[i] = wb.data;
    end
    // r15 is cleared at the end of every instruction
    rf_next[ZERO_REG] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= '0;
      rf[FLAG_REG] <= FLAG_RESET;
    end else if (commit) begin
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= rf_next[i];
    end
  end

  assign rd_x     = rf[rd_x_addr];
  assign rd_y     = rf[rd_y_addr];
  assign r0       = rf[ACC_REG];
  assign r1       = rf[1];
  assign r13      = rf[COUNT_REG];
  assign r14      = rf[FLAG_REG];
  assign r0_next  = rf_next[ACC_REG];
  assign r14_next = rf_next[FLAG_REG];

endmodule

[sv/ncx_exec.sv]
// ----------------------------------------------------------------------------
// ncx_exec
// instruction decode: register writes, alu use and redirect decision
// ----------------------------------------------------------------------------
module ncx_exec
  import ncx_pkg::*;
(
  input  instr_t           instr,
  input  logic [REG_W-1:0] rd_x,
  input  logic [REG_W-1:0] rd_y,
  input  logic [REG_W-1:0] r0,
  input  logic [REG_W-1:0] r1,
  input  logic [REG_W-1:0] r13,
  input  logic [REG_W-1:0] r14,
  output wr_t              wa,
  output wr_t              wb,
  output ctl_t             ctl
);

  logic [REG_W-1:0] alu_res;
  logic [REG_W-1:0] alu_flags;
  logic [REG_W-1:0] cnt_dec;
  logic             cond;

  ncx_alu u_alu (
    .mode      (instr.arg_first),
    .a         (r0),
    .b         (r1),
    .flags_old (r14),
    .res       (alu_res),
    .flags_new (alu_flags)
  );

  // selected flag differs from the invert bit
  assign cond    = r14[instr.arg_first[2:0]] != instr.arg_first[3];
  assign cnt_dec = r13 - 8'h01;

  always_comb begin
    wa  = '0;
    wb  = '0;
    ctl = '{halted: 1'b0, kind: RDR_NONE, target: '0};
    case (op_t'(instr.op))
      OP_STOP:  ctl.halted = 1'b1;
      OP_WRITE: wa = '{en: 1'b1, addr: instr.arg_first,
                       data: {instr.arg_second, instr.arg_third}};
      OP_COPY:  wa = '{en: 1'b1, addr: instr.arg_second, data: rd_x};
      OP_SWAP: begin
        wa = '{en: 1'b1, addr: instr.arg_first,  data: rd_y};
        wb = '{en: 1'b1, addr: instr.arg_second, data: rd_x};
      end
      OP_ALU: begin
        wa = '{en: 1'b1, addr: ACC_REG,  data: alu_res};
        wb = '{en: 1'b1, addr: FLAG_REG, data: alu_flags};
      end
      OP_CMP:   wb = '{en: 1'b1, addr: FLAG_REG, data: alu_flags};
      OP_JUMP: begin
        if (cond) begin
          ctl.kind   = RDR_JUMP;
          ctl.target = {instr.arg_second, instr.arg_third};
        end
      end
      OP_BRANCH: begin
        if (cond) begin
          ctl.kind   = RDR_BRANCH;
          ctl.target = {instr.arg_second, instr.arg_third};
        end
      end
      OP_RET:   ctl.kind = RDR_RETURN;
      OP_COUNT: begin
        wa = '{en: 1'b1, addr: COUNT_REG, data: cnt_dec};
        if (cnt_dec != '0) begin
          ctl.kind   = RDR_JUMP;
          ctl.target = {instr.arg_first, instr.arg_second};
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/nibble_cpu_execute_unit.sv]
// ----------------------------------------------------------------------------
// nibble_cpu_execute_unit
// executes one decoded nibble instruction per transfer on a 16 x 8 file
// ----------------------------------------------------------------------------
// usage
//   slave channel s_*: one decoded instruction per transfer, tdata holds
//   op, arg_first, arg_second, arg_third as four nibbles from the low end
//   master channel m_*: one result per instruction; tuser carries halted
//   and the redirect kind, tdata the target, r14 and r0 after the instruction
//   path: an instruction goes through the input register, then the execute
//   logic settles its result into the result register
//   throughput: one instruction per cycle without stalls; the execute step
//   reads the file, goes through the alu and writes the file back in the same
//   cycle, so each instruction sees the state left by the one before it
//   a stalled receiver holds the result register; the input register keeps
//   one more instruction and s_tready drops only when both are full
//   reset: synchronous, clears both valid flags and loads the register file
//   with zeros except the flag register r14, which starts at 0x03
//   the file changes only when an instruction moves into the result register
// ----------------------------------------------------------------------------
module nibble_cpu_execute_unit
  import ncx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // op, arg_first, arg_second, arg_third
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // redirect_target, flags_now, accumulator_now
  output logic [OUT_DATA_W-1:0] m_tdata,
  // halted, redirect_kind, zero fill
  output logic [OUT_USER_W-1:0] m_tuser
);

  instr_t           instr;
  logic             in_valid;
  logic             advance;

  wr_t              wa;
  wr_t              wb;
  ctl_t             ctl;
  logic [REG_W-1:0] rd_x;
  logic [REG_W-1:0] rd_y;
  logic [REG_W-1:0] r0;
  logic [REG_W-1:0] r1;
  logic [REG_W-1:0] r13;
  logic [REG_W-1:0] r14;
  logic [REG_W-1:0] r0_next;
  logic [REG_W-1:0] r14_next;

  // instruction leaves the input register when the result slot is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      instr <= '{op:         s_tdata[3:0],
                 arg_first:  s_tdata[7:4],
                 arg_second: s_tdata[11:8],
                 arg_third:  s_tdata[15:12]};
    end
  end

  ncx_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .commit    (advance),
    .wa        (wa),
    .wb        (wb),
    .rd_x_addr (instr.arg_first),
    .rd_y_addr (instr.arg_second),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .r0        (r0),
    .r1        (r1),
    .r13       (r13),
    .r14       (r14),
    .r0_next   (r0_next),
    .r14_next  (r14_next)
  );

  ncx_exec u_exec (
    .instr (instr),
    .rd_x  (rd_x),
    .rd_y  (rd_y),
    .r0    (r0),
    .r1    (r1),
    .r13   (r13),
    .r14   (r14),
    .wa    (wa),
    .wb    (wb),
    .ctl   (ctl)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {r0_next, r14_next, ctl.target};
      m_tuser <= {{(OUT_USER_W-1-KIND_W){1'b0}}, ctl.kind, ctl.halted};
    end
  end

endmodule

[sv/ncx_checker.sv]
// ----------------------------------------------------------------------------
// ncx_checker
// port-level assertions for the nibble cpu execute unit, bound to the top
// ----------------------------------------------------------------------------
`include "nibble_cpu_execute_unit_macros.svh"

module ncx_checker
  import ncx_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  logic                             stall;
  logic                             halted;
  logic                             no_target;
  logic [KIND_W-1:0]                kind;
  logic [REG_W-1:0]                 target;
  logic [OUT_USER_W+OUT_DATA_W-1:0] out_word;

  assign stall     = m_tvalid && !m_tready;
  assign halted    = m_tuser[0];
  assign kind      = m_tuser[2:1];
  assign target    = m_tdata[7:0];
  assign no_target = (kind == RDR_NONE) || (kind == RDR_RETURN);
  assign out_word  = {m_tuser, m_tdata};

  // a stalled result holds its payload
  `NCX_ASSERT_NEXT(a_hold, clk, rst, stall, m_tvalid && $stable(out_word), "held result changed")

  // no result in the first cycle after reset
  `NCX_ASSERT(a_reset_empty, clk, rst, $past(rst) |-> !m_tvalid, "result valid right after reset")

  // stop never redirects
  `NCX_ASSERT(a_halt_no_rdr, clk, rst, m_tvalid && halted |-> kind == RDR_NONE, "stop with redirect")

  // no target without a jump or a branch
  `NCX_ASSERT(a_target_zero, clk, rst, m_tvalid && no_target |-> target == '0, "stray target")

endmodule

bind nibble_cpu_execute_unit ncx_checker u_ncx_checker (.*);

[sim/nibble_cpu_execute_unit_tb.sv]
// ----------------------------------------------------------------------------
// nibble_cpu_execute_unit_tb
// self-checking bench: a scoreboard predicts each result from its own copy
// of the register file, the streaming sides idle and stall at random
// ----------------------------------------------------------------------------
module nibble_cpu_execute_unit_tb import ncx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 40;

  // opcodes with no function, and flag selectors used by the directed part
  localparam logic [NIB_W-1:0] OP_SPARE_LO  = 4'h6;
  localparam logic [NIB_W-1:0] OP_SPARE_HI  = 4'hf;
  localparam logic [NIB_W-1:0] SEL_TRUE     = 4'h0;
  localparam logic [NIB_W-1:0] SEL_ZERO     = 4'h1;
  localparam logic [NIB_W-1:0] SEL_NOT_TRUE = 4'h8;

  typedef struct {
    logic             halted;
    rdr_kind_t        kind;
    logic [REG_W-1:0] target;
    logic [REG_W-1:0] flags;
    logic [REG_W-1:0] acc;
  } exec_result_t;

  // predicts the outcome of every accepted instruction and checks results
  class exec_scoreboard;
    logic [REG_W-1:0] regs [NUM_REGS];
    exec_result_t     result_q [$];
    int               errors;
    int               checked;
    int               redirects;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[FLAG_REG] = FLAG_RESET;
      errors    = 0;
      checked   = 0;
      redirects = 0;
    endfunction

    function logic [REG_W-1:0] alu_calc(alu_mode_t mode, logic [REG_W-1:0] a,
                                        logic [REG_W-1:0] b, output logic loss);
      logic [REG_W:0]   wide;
      logic [REG_W-1:0] r;
      wide = {1'b0, a} + {1'b0, b};
      loss = 1'b0;
      case (mode)
        ALU_ADD: begin
          r    = wide[REG_W-1:0];
          loss = wide[REG_W];
        end
        ALU_SUB: begin
          // loss keeps the carry of the sum, not a borrow
          r    = a - b;
          loss = wide[REG_W];
        end
        ALU_INC: r = a + 8'd1;
        ALU_DEC: r = a - 8'd1;
        ALU_NOT: r = ~a;
        ALU_OR:  r = a | b;
        ALU_AND: r = a & b;
        ALU_XOR: r = a ^ b;
        ALU_SHL: begin
          r    = {a[6:0], 1'b0};
          loss = a[7];
        end
        ALU_SHR: begin
          r    = {1'b0, a[7:1]};
          loss = a[0];
        end
        ALU_ROL: r = {a[6:0], a[7]};
        ALU_ROR: r = {a[0], a[7:1]};
        ALU_NEG: r = 8'd0 - a;
        ALU_ISZ: r = (a == 8'd0) ? 8'd1 : 8'd0;
        ALU_LOG: begin
          // index of the highest set bit, all ones for zero
          r = 8'hff;
          for (int i = 0; i < REG_W; i++) if (a[i]) r = 8'(i);
          loss = (a == 8'd0);
        end
        default: r = a;
      endcase
      return r;
    endfunction

    function logic [REG_W-1:0] flags_of(logic [REG_W-1:0] r, logic loss);
      logic [REG_W-1:0] f;
      f    = 8'h01 | (regs[FLAG_REG] & FLAG_KEEP);
      f[1] = (r == 8'd0);
      f[2] = r[7];
      f[3] = (r != 8'd0) && !r[7];
      f[4] = r[0];
      f[5] = loss;
      return f;
    endfunction

    function logic taken(logic [NIB_W-1:0] sel);
      return regs[FLAG_REG][sel[2:0]] != sel[3];
    endfunction

    // one accepted instruction: update the file, queue the expected result
    function void note_instr(logic [IN_DATA_W-1:0] word);
      exec_result_t     e;
      op_t              op;
      logic [NIB_W-1:0] x, y, z;
      logic [REG_W-1:0] tmp, res;
      logic             loss;
      op = op_t'(word[3:0]);
      x  = word[7:4];
      y  = word[11:8];
      z  = word[15:12];
      e.halted = 1'b0;
      e.kind   = RDR_NONE;
      e.target = '0;
      case (op)
        OP_STOP:  e.halted = 1'b1;
        OP_WRITE: regs[x] = {y, z};
        OP_COPY:  regs[y] = regs[x];
        OP_SWAP: begin
          tmp     = regs[x];
          regs[x] = regs[y];
          regs[y] = tmp;
        end
        OP_ALU: begin
          res            = alu_calc(alu_mode_t'(x), regs[ACC_REG], regs[1], loss);
          regs[ACC_REG]  = res;
          regs[FLAG_REG] = flags_of(res, loss);
        end
        OP_CMP: begin
          res            = alu_calc(alu_mode_t'(x), regs[ACC_REG], regs[1], loss);
          regs[FLAG_REG] = flags_of(res, loss);
        end
        OP_JUMP, OP_BRANCH: begin
          if (taken(x)) begin
            e.kind   = (op == OP_JUMP) ? RDR_JUMP : RDR_BRANCH;
            e.target = {y, z};
          end
        end
        OP_RET: e.kind = RDR_RETURN;
        OP_COUNT: begin
          regs[COUNT_REG] = regs[COUNT_REG] - 8'd1;
          if (regs[COUNT_REG] != 8'd0) begin
            e.kind   = RDR_JUMP;
            e.target = {x, y};
          end
        end
        default: ;
      endcase
      regs[ZERO_REG] = '0;
      e.flags = regs[FLAG_REG];
      e.acc   = regs[ACC_REG];
      if (e.kind != RDR_NONE) redirects++;
      result_q.push_back(e);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      exec_result_t e;
      if (result_q.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        errors++;
        return;
      end
      e = result_q.pop_front();
      checked++;
      if (user[0] !== e.halted) begin
        $error("halted: expected %0h, got %0h", e.halted, user[0]);
        errors++;
      end
      if (user[2:1] !== e.kind) begin
        $error("redirect_kind: expected %0h, got %0h", e.kind, user[2:1]);
        errors++;
      end
      if (data[7:0] !== e.target) begin
        $error("redirect_target: expected %0h, got %0h", e.target, data[7:0]);
        errors++;
      end
      if (data[15:8] !== e.flags) begin
        $error("flags_now: expected %0h, got %0h", e.flags, data[15:8]);
        errors++;
      end
      if (data[23:16] !== e.acc) begin
        $error("accumulator_now: expected %0h, got %0h", e.acc, data[23:16]);
        errors++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void drain_check();
      if (result_q.size() != 0) begin
        $error("%0d results never arrived", result_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  exec_scoreboard sb;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             rx_hold_left;
  int             sent;

  nibble_cpu_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both sides sampled at the rising edge, instruction noted before result
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_instr(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("nibble_cpu_execute_unit_tb: errors");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] instr(logic [NIB_W-1:0] op, logic [NIB_W-1:0] x,
                                                 logic [NIB_W-1:0] y, logic [NIB_W-1:0] z);
    return {z, y, x, op};
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_instr(input logic [IN_DATA_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // weighted toward register loads, alu work and control flow
  function automatic logic [IN_DATA_W-1:0] random_instr();
    int               pick;
    logic [NIB_W-1:0] op, x, y, z;
    pick = $urandom_range(99);
    x    = 4'($urandom_range(15));
    y    = 4'($urandom_range(15));
    z    = 4'($urandom_range(15));
    if (pick < 22) begin
      op = OP_WRITE;
      case ($urandom_range(4))
        0: x = ACC_REG;
        1: x = 4'h1;
        2: x = COUNT_REG;
        3: x = FLAG_REG;
        default: ;
      endcase
      // short loop counts so the count instruction reaches zero
      if (x == COUNT_REG && $urandom_range(1)) y = 4'h0;
    end
    else if (pick < 44) op = OP_ALU;
    else if (pick < 54) op = OP_CMP;
    else if (pick < 63) op = OP_JUMP;
    else if (pick < 70) op = OP_BRANCH;
    else if (pick < 74) op = OP_RET;
    else if (pick < 82) op = OP_COUNT;
    else if (pick < 86) op = OP_COPY;
    else if (pick < 90) op = OP_SWAP;
    else if (pick < 92) op = OP_STOP;
    else op = 4'($urandom_range(15));
    return instr(op, x, y, z);
  endfunction

  initial begin
    sb           = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 0;
    sent         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, every opcode and the corner cases
    tx_idle_pct = 24;
    rx_idle_pct = 60;
    send_instr(instr(OP_STOP, 4'h0, 4'h0, 4'h0));
    send_instr(instr(OP_WRITE, ACC_REG, 4'hf, 4'hf));
    send_instr(instr(OP_WRITE, 4'h1, 4'h0, 4'h1));
    send_instr(instr(OP_ALU, ALU_ADD, 4'h0, 4'h0));     // wraps to zero with loss
    send_instr(instr(OP_CMP, ALU_SUB, 4'h0, 4'h0));
    send_instr(instr(OP_ALU, ALU_LOG, 4'h0, 4'h0));     // log of zero
    send_instr(instr(OP_WRITE, ZERO_REG, 4'ha, 4'h5));  // zero register cleared after
    send_instr(instr(OP_SWAP, ACC_REG, ZERO_REG, 4'h0));
    send_instr(instr(OP_COPY, FLAG_REG, 4'h2, 4'h0));
    send_instr(instr(OP_JUMP, SEL_TRUE, 4'hf, 4'hf));
    send_instr(instr(OP_JUMP, SEL_NOT_TRUE, 4'h1, 4'h2));
    send_instr(instr(OP_BRANCH, SEL_ZERO, 4'h0, 4'h0));
    send_instr(instr(OP_BRANCH, SEL_NOT_TRUE | SEL_ZERO, 4'h8, 4'h0));
    send_instr(instr(OP_RET, 4'hf, 4'hf, 4'hf));
    send_instr(instr(OP_WRITE, COUNT_REG, 4'h0, 4'h1));
    send_instr(instr(OP_COUNT, 4'hf, 4'hf, 4'h0));      // reaches zero, no jump
    send_instr(instr(OP_COUNT, 4'ha, 4'h5, 4'h0));      // wraps to 0xff, jumps
    send_instr(instr(OP_WRITE, ACC_REG, 4'h8, 4'h1));
    send_instr(instr(OP_ALU, ALU_ROR, 4'h0, 4'h0));
    send_instr(instr(OP_ALU, ALU_SHL, 4'h0, 4'h0));
    send_instr(instr(OP_ALU, ALU_PASS, 4'h0, 4'h0));
    send_instr(instr(OP_SPARE_LO, 4'h3, 4'hc, 4'h9));
    send_instr(instr(OP_SPARE_HI, 4'hf, 4'hf, 4'hf));

    // sender idles less than the receiver
    repeat (530) send_instr(random_instr());
    pause_until_drained();

    // the other way round
    tx_idle_pct = 60;
    rx_idle_pct = 24;
    repeat (550) send_instr(random_instr());

    // no idling, with one long receiver hold part way through
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (200) send_instr(random_instr());
    rx_hold_left = LONG_HOLD;
    repeat (300) send_instr(random_instr());
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.drain_check();

    $display("covered %0d instructions and %0d results, %0d of them redirects,",
             sent, sb.checked, sb.redirects);
    $display("under both idle patterns, no idling, a long output hold and a full drain");
    if (sb.errors == 0) $display("nibble_cpu_execute_unit_tb: clean");
    else $display("nibble_cpu_execute_unit_tb: errors");
    $finish;
  end

endmodule
